### sv/char_lcd_nibble_sequencer_unit_defines.svh
// assertion macros shared by the nibble sequencer modules
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define CLNS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CLNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/clns_pkg.sv
// types, constants and tables of the nibble sequencer
package clns_pkg;

  localparam int unsigned LINE_CHARS = 16;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [7:0]  ADDR_LINE1 = 8'h80;
  localparam logic [7:0]  ADDR_LINE2 = 8'hC0;
  localparam logic [7:0]  CMD_CLEAR  = 8'h01;
  localparam logic [7:0]  CMD_CUR_ON = 8'h0F;
  localparam logic [7:0]  CMD_CUR_OFF = 8'h0C;
  localparam logic [7:0]  CMD_DISP_OFF = 8'h08;
  localparam logic [7:0]  CNT_MAX    = 8'hFF;

  localparam logic [15:0] BASE_WAIT  = 16'd2000;
  localparam logic [15:0] POWER_WAIT = 16'd41000;
  localparam logic [15:0] SETTLE_WAIT = 16'd5000;
  localparam logic [15:0] SHORT_WAIT = 16'd100;

  localparam logic [3:0]  INIT_LAST  = 4'd13;
  localparam logic [3:0]  BYTE_LAST  = 4'd1;
  localparam logic [3:0]  WRAP_LAST  = 4'd3;

  typedef enum logic [2:0] {
    FN_INIT     = 3'd0,
    FN_CLEAR    = 3'd1,
    FN_START    = 3'd2,
    FN_CHAR     = 3'd3,
    FN_CUR_ON   = 3'd4,
    FN_CUR_OFF  = 3'd5,
    FN_DISP_OFF = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    JK_INIT,
    JK_BYTE,
    JK_WRAP_CHAR
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic       rs;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic        push;
    logic        full;
  } q_ctrl_t;

  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0, 4'd1, 4'd2: n = 4'h3;
      4'd3, 4'd4:       n = 4'h2;
      4'd5, 4'd7:       n = 4'h8;
      4'd9:             n = 4'h1;
      4'd11:            n = 4'h6;
      4'd13:            n = 4'hF;
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] init_wait(input logic [3:0] idx);
    logic [15:0] w;
    case (idx)
      4'd0, 4'd6:                     w = POWER_WAIT + BASE_WAIT;
      4'd1:                           w = SETTLE_WAIT + BASE_WAIT;
      4'd2, 4'd3, 4'd4, 4'd8, 4'd10,
      4'd12:                          w = SHORT_WAIT + BASE_WAIT;
      default:                        w = BASE_WAIT;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] last_idx(input job_kind_e kind);
    logic [3:0] l;
    case (kind)
      JK_INIT:      l = INIT_LAST;
      JK_WRAP_CHAR: l = WRAP_LAST;
      default:      l = BYTE_LAST;
    endcase
    return l;
  endfunction

endpackage

### sv/clns_in_if.sv
// command request channel
interface clns_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [1:0] line;
  logic [7:0] column;
  logic [7:0] char_code;

  modport source (output valid, func, line, column, char_code, input ready);
  modport sink   (input valid, func, line, column, char_code, output ready);
endinterface

### sv/clns_out_if.sv
// enable pulse request channel
interface clns_out_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [15:0] wait_us;
  logic        last;

  modport source (output valid, reg_select, nibble, wait_us, last, input ready);
  modport sink   (input valid, reg_select, nibble, wait_us, last, output ready);
endinterface

### sv/clns_front.sv
// front end: accepts commands, tracks cursor position, turns commands into jobs
module clns_front
  import clns_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  clns_in_if.sink          in_req,
  input  logic             q_full_i,
  output q_ctrl_t          q_ctrl_o,
  output job_t             job_o
);

  logic       second_q, second_d;
  logic [7:0] count_q, count_d;
  logic       accept;
  logic       has_job;
  job_t       job;
  logic [7:0] addr_base;

  assign in_req.ready = !q_full_i;
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    second_d  = second_q;
    count_d   = count_q;
    has_job   = 1'b1;
    job.kind  = JK_BYTE;
    job.rs    = 1'b0;
    job.data  = in_req.char_code;
    addr_base = (in_req.line == 2'd2) ? ADDR_LINE2 : ADDR_LINE1;
    case (func_e'(in_req.func))
      FN_INIT:     job.kind = JK_INIT;
      FN_CLEAR:    job.data = CMD_CLEAR;
      FN_START: begin
        second_d = (in_req.line == 2'd2);
        count_d  = in_req.column;
        job.data = addr_base + in_req.column;
      end
      FN_CHAR: begin
        job.rs = 1'b1;
        if (count_q >= 8'(LINE_CHARS)) begin
          if (second_q) begin
            // display full, character dropped
            has_job = 1'b0;
          end else begin
            second_d = 1'b1;
            count_d  = 8'd1;
            job.kind = JK_WRAP_CHAR;
          end
        end else if (count_q != CNT_MAX) begin
          count_d = count_q + 8'd1;
        end
      end
      FN_CUR_ON:   job.data = CMD_CUR_ON;
      FN_CUR_OFF:  job.data = CMD_CUR_OFF;
      FN_DISP_OFF: job.data = CMD_DISP_OFF;
      default:     has_job = 1'b0;
    endcase
  end

  assign q_ctrl_o.push = accept && has_job;
  assign q_ctrl_o.full = q_full_i;
  assign job_o         = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
      count_q  <= 8'd0;
    end else if (accept) begin
      second_q <= second_d;
      count_q  <= count_d;
    end
  end

endmodule

### sv/clns_queue.sv
// short job queue between front and back
`include "char_lcd_nibble_sequencer_unit_defines.svh"
module clns_queue
  import clns_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_ctrl_t ctrl_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    valid_o,
  output job_t    job_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;

  assign push    = ctrl_i.push;
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ptr_inc(wr_q);
      if (pop_i) rd_q <= ptr_inc(rd_q);
      if (push && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  `CLNS_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "queue overfilled")
  `CLNS_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push, !ctrl_i.full, "push into full queue")
  `CLNS_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop_i, valid_o, "pop from empty queue")

endmodule

### sv/clns_back.sv
// back end: expands jobs into enable pulses behind an output register
`include "char_lcd_nibble_sequencer_unit_defines.svh"
module clns_back
  import clns_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  job_t      q_job_i,
  output logic      pop_o,
  clns_out_if.source out_req
);

  job_t        job_q, job_d;
  logic        busy_q, busy_d;
  logic [3:0]  idx_q, idx_d;
  logic        ov_q;
  logic        rs_q, last_q;
  logic [3:0]  nib_q;
  logic [15:0] wait_q;
  logic        emit, is_last;
  logic        p_rs;
  logic [3:0]  p_nib;
  logic [15:0] p_wait;

  assign is_last = (idx_q == last_idx(job_q.kind));
  assign emit    = busy_q && (!ov_q || out_req.ready);
  assign pop_o   = q_valid_i && (!busy_q || (emit && is_last));

  // pulse for the current job and index
  always_comb begin
    p_rs   = job_q.rs;
    p_wait = BASE_WAIT;
    p_nib  = idx_q[0] ? job_q.data[3:0] : job_q.data[7:4];
    case (job_q.kind)
      JK_INIT: begin
        p_rs   = 1'b0;
        p_nib  = init_nibble(idx_q);
        p_wait = init_wait(idx_q);
      end
      JK_WRAP_CHAR: begin
        // address of second line first, then the character
        if (!idx_q[1]) begin
          p_rs  = 1'b0;
          p_nib = idx_q[0] ? ADDR_LINE2[3:0] : ADDR_LINE2[7:4];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    job_d  = job_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      job_d  = q_job_i;
      idx_d  = 4'd0;
    end else if (emit) begin
      if (is_last) busy_d = 1'b0;
      idx_d = idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 4'd0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (emit) ov_q <= 1'b1;
      else if (out_req.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (emit) begin
      rs_q   <= p_rs;
      nib_q  <= p_nib;
      wait_q <= p_wait;
      last_q <= is_last;
    end
  end

  assign out_req.valid      = ov_q;
  assign out_req.reg_select = rs_q;
  assign out_req.nibble     = nib_q;
  assign out_req.wait_us    = wait_q;
  assign out_req.last       = last_q;

  `CLNS_ASSERT_NOW(a_idx_bound, clk_i, rst_ni, busy_q, idx_q <= last_idx(job_q.kind), "pulse index past end of job")
  `CLNS_ASSERT_NEXT(a_idx_restart, clk_i, rst_ni, pop_o, idx_q == 4'd0 && busy_q, "new job did not restart at first pulse")
  `CLNS_ASSERT_NEXT(a_last_done, clk_i, rst_ni, emit && is_last && !pop_o, !busy_q && last_q, "job kept running after its last pulse")

endmodule

### sv/char_lcd_nibble_sequencer_unit.sv
// top level of the character display nibble sequencer
// Usage:
//   in_req carries one command per request (init, clear, start print, character,
//   cursor on, cursor off, display off); out_req carries one enable pulse per
//   request with RS level, nibble, minimum wait in us and a last mark.
//   Both channels move a request when valid and ready are high at a clock edge.
// Data flow and throughput:
//   the front classifies a command in its accept cycle and hands a job to a
//   two-entry queue; the back pulls jobs into its job register and, while
//   out_req.ready is high, emits one pulse per cycle into the output register.
//   Init expands into 14 pulses, a character after line overflow into 4, every
//   other command into 2; back to back jobs stream with no gap between them.
//   Display-full characters and func code 7 are accepted and give no pulses.
// Reset:
//   rst_ni clears the cursor to line 1, column 0, empties the queue and the
//   output register.
// Stalls:
//   while out_req.ready is low the pending pulse holds; the back stops, the
//   queue fills and in_req.ready drops once both queue entries are taken.
module char_lcd_nibble_sequencer_unit
  import clns_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  clns_in_if.sink     in_req,
  clns_out_if.source  out_req
);

  q_ctrl_t q_ctrl;
  job_t    push_job;
  job_t    head_job;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;

  clns_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req   (in_req),
    .q_full_i (q_full),
    .q_ctrl_o (q_ctrl),
    .job_o    (push_job)
  );

  clns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  clns_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (head_job),
    .pop_o     (q_pop),
    .out_req   (out_req)
  );

endmodule

### bench/char_lcd_nibble_sequencer_unit_tb.sv
// self-checking bench for the character display nibble sequencer
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_unit_tb
  import clns_pkg::*;
;

  localparam logic [2:0]  FN_UNUSED    = 3'd7;
  localparam int unsigned LINE_LEN     = LINE_CHARS;
  localparam logic [15:0] WAIT_BASE    = 16'd2000;
  localparam logic [15:0] WAIT_POWER   = 16'd43000;
  localparam logic [15:0] WAIT_SETTLE  = 16'd7000;
  localparam logic [15:0] WAIT_SHORT   = 16'd2100;
  localparam int unsigned TOTAL_ITEMS  = 310;
  localparam int unsigned MAX_IDLE     = 18;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;

  localparam logic [3:0] INIT_NIBS [14] = '{
    4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0, 4'h8, 4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hF
  };
  localparam logic [15:0] INIT_WAITS [14] = '{
    WAIT_POWER, WAIT_SETTLE, WAIT_SHORT, WAIT_SHORT, WAIT_SHORT, WAIT_BASE, WAIT_POWER,
    WAIT_BASE, WAIT_SHORT, WAIT_BASE, WAIT_SHORT, WAIT_BASE, WAIT_SHORT, WAIT_BASE
  };

  typedef struct {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_us;
    logic        last;
  } pulse_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  clns_in_if  cmd_if ();
  clns_out_if pulse_if ();

  char_lcd_nibble_sequencer_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (cmd_if),
    .out_req (pulse_if)
  );

  always #5 clk_i = ~clk_i;

  pulse_t      due_pulses [$];
  logic        pred_second_line = 1'b0;
  logic [7:0]  pred_col = 8'd0;
  int unsigned fail_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          src_idle_on = 1'b1;
  bit          snk_stall_on = 1'b1;

  function automatic void push_pulse(input logic rs, input logic [3:0] nib,
                                     input logic [15:0] w);
    pulse_t p;
    p.reg_select = rs;
    p.nibble     = nib;
    p.wait_us    = w;
    p.last       = 1'b0;
    due_pulses.push_back(p);
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] b);
    push_pulse(rs, b[7:4], WAIT_BASE);
    push_pulse(rs, b[3:0], WAIT_BASE);
  endfunction

  // expected pulses of one command, updates the cursor copy
  function automatic void predict_pulses(input logic [2:0] fn, input logic [1:0] ln,
                                         input logic [7:0] col, input logic [7:0] code);
    int     n0;
    logic   [7:0] addr;
    pulse_t p;
    n0 = due_pulses.size();
    case (fn)
      FN_INIT: begin
        for (int i = 0; i < 14; i++) push_pulse(1'b0, INIT_NIBS[i], INIT_WAITS[i]);
      end
      FN_CLEAR:    push_byte(1'b0, CMD_CLEAR);
      FN_CUR_ON:   push_byte(1'b0, CMD_CUR_ON);
      FN_CUR_OFF:  push_byte(1'b0, CMD_CUR_OFF);
      FN_DISP_OFF: push_byte(1'b0, CMD_DISP_OFF);
      FN_START: begin
        pred_second_line = (ln == 2'd2);
        pred_col = col;
        addr = (pred_second_line ? ADDR_LINE2 : ADDR_LINE1) + col;
        push_byte(1'b0, addr);
      end
      FN_CHAR: begin
        // full second line drops the character
        if (!(pred_col >= LINE_LEN && pred_second_line)) begin
          if (pred_col >= LINE_LEN) begin
            pred_second_line = 1'b1;
            pred_col = 8'd0;
            push_byte(1'b0, ADDR_LINE2);
          end
          push_byte(1'b1, code);
          if (pred_col != 8'hFF) pred_col = pred_col + 8'd1;
        end
      end
      default: ;
    endcase
    if (due_pulses.size() > n0) begin
      p = due_pulses.pop_back();
      p.last = 1'b1;
      due_pulses.push_back(p);
    end
  endfunction

  function automatic void check_pulse();
    pulse_t exp_p;
    if (due_pulses.size() == 0) begin
      if (fail_cnt < 10)
        $display("unexpected pulse: rs=%0d nib=%h wait=%0d last=%0d", pulse_if.reg_select,
                 pulse_if.nibble, pulse_if.wait_us, pulse_if.last);
      fail_cnt++;
    end else begin
      exp_p = due_pulses.pop_front();
      if (exp_p.reg_select !== pulse_if.reg_select || exp_p.nibble !== pulse_if.nibble ||
          exp_p.wait_us !== pulse_if.wait_us || exp_p.last !== pulse_if.last) begin
        if (fail_cnt < 10) begin
          $display("pulse mismatch: expected rs=%0d nib=%h wait=%0d last=%0d",
                   exp_p.reg_select, exp_p.nibble, exp_p.wait_us, exp_p.last);
          $display("                got      rs=%0d nib=%h wait=%0d last=%0d",
                   pulse_if.reg_select, pulse_if.nibble, pulse_if.wait_us, pulse_if.last);
        end
        fail_cnt++;
      end
    end
  endfunction

  // sampling of both channels and the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready)
        predict_pulses(cmd_if.func, cmd_if.line, cmd_if.column, cmd_if.char_code);
      if (pulse_if.valid && pulse_if.ready)
        check_pulse();
      if ((cmd_if.valid && cmd_if.ready) || (pulse_if.valid && pulse_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
          $display("char_lcd_nibble_sequencer_unit test failed");
          $finish;
        end
      end
    end
  end

  // pulse receiver with random stalls
  initial begin
    int unsigned stall;
    pulse_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = snk_stall_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        pulse_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pulse_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(pulse_if.valid && rst_ni));
    end
  end

  // valid stays high after a request unless a gap follows
  task automatic send_command(input logic [2:0] fn, input logic [1:0] ln,
                              input logic [7:0] col, input logic [7:0] code);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.func      <= fn;
    cmd_if.line      <= ln;
    cmd_if.column    <= col;
    cmd_if.char_code <= code;
    do @(posedge clk_i); while (!cmd_if.ready);
    sent_cnt++;
  endtask

  // command with random line, column and character fields
  task automatic send_random(input logic [2:0] fn);
    send_command(fn, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (due_pulses.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_char_after_reset();
    send_command(FN_CHAR, 2'd2, 8'd9, 8'h41);
  endtask

  task automatic test_init();
    send_command(FN_INIT, 2'd3, 8'hFF, 8'hFF);
  endtask

  task automatic test_short_commands();
    send_command(FN_CLEAR, 2'd0, 8'd0, 8'd0);
    send_command(FN_CUR_ON, 2'd1, 8'h55, 8'hAA);
    send_command(FN_CUR_OFF, 2'd2, 8'hAA, 8'h55);
    send_command(FN_DISP_OFF, 2'd3, 8'hFF, 8'hFF);
    send_command(FN_UNUSED, 2'd2, 8'd3, 8'h30);
  endtask

  task automatic test_start_print();
    send_command(FN_START, 2'd0, 8'd0, 8'hFF);
    send_command(FN_START, 2'd1, 8'hFF, 8'd0);
    send_command(FN_START, 2'd2, 8'h40, 8'd0);   // address wraps to zero
    send_command(FN_START, 2'd3, 8'h7F, 8'd0);
    send_command(FN_START, 2'd2, 8'hFF, 8'd0);
  endtask

  task automatic test_line_wrap();
    send_command(FN_START, 2'd0, 8'd14, 8'd0);
    send_command(FN_CHAR, 2'd3, 8'hFF, 8'h00);
    send_command(FN_CHAR, 2'd0, 8'd0, 8'hFF);
    send_command(FN_CHAR, 2'd1, 8'd7, 8'h5A);    // moves to the second line
    send_command(FN_START, 2'd2, 8'd15, 8'd0);
    send_command(FN_CHAR, 2'd0, 8'd0, 8'h21);
    send_command(FN_CHAR, 2'd0, 8'd0, 8'h22);    // display full, dropped
  endtask

  task automatic test_drain_pause();
    send_command(FN_INIT, 2'd0, 8'd0, 8'd0);
    wait_drained();
    send_command(FN_CLEAR, 2'd1, 8'd1, 8'd1);
    send_command(FN_CHAR, 2'd0, 8'd0, 8'h7E);
  endtask

  task automatic test_random();
    int unsigned pick;
    int unsigned run_len;
    logic [2:0]  fn;
    logic [7:0]  col;
    while (sent_cnt < TOTAL_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        snk_stall_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // start print followed by a run of characters
        if ($urandom_range(0, 4) != 0) col = 8'($urandom_range(0, 20));
        else col = 8'($urandom_range(0, 255));
        send_command(FN_START, 2'($urandom_range(0, 3)), col, 8'($urandom_range(0, 255)));
        run_len = $urandom_range(1, 24);
        repeat (run_len) send_random(FN_CHAR);
      end else if (pick < 65) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) send_random(FN_CHAR);
      end else if (pick < 92) begin
        case ($urandom_range(0, 4))
          0:       fn = FN_INIT;
          1:       fn = FN_CLEAR;
          2:       fn = FN_CUR_ON;
          3:       fn = FN_CUR_OFF;
          default: fn = FN_DISP_OFF;
        endcase
        send_random(fn);
      end else begin
        send_random(FN_UNUSED);
      end
    end
  endtask

  initial begin
    cmd_if.valid     <= 1'b0;
    cmd_if.func      <= FN_INIT;
    cmd_if.line      <= 2'd0;
    cmd_if.column    <= 8'd0;
    cmd_if.char_code <= 8'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_char_after_reset();
    test_init();
    test_short_commands();
    test_start_print();
    test_line_wrap();
    test_drain_pause();
    test_random();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_pulses.size() != 0) begin
      $display("%0d expected pulses never arrived", due_pulses.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("char_lcd_nibble_sequencer_unit test passed");
    end else begin
      $display("char_lcd_nibble_sequencer_unit test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/clns_pkg.sv
sv/clns_in_if.sv
sv/clns_out_if.sv
sv/clns_front.sv
sv/clns_queue.sv
sv/clns_back.sv
sv/char_lcd_nibble_sequencer_unit.sv
bench/char_lcd_nibble_sequencer_unit_tb.sv
